@@ hw/rtl/hsd_pkg.sv @@
`default_nettype none
package hsd_pkg;

  localparam int unsigned NODE_COUNT  = 1024;
  localparam int unsigned STACK_DEPTH = 64;

  localparam int unsigned NODE_AW  = $clog2(NODE_COUNT);
  localparam int unsigned NODE_IW  = NODE_AW + 1;
  localparam int unsigned STACK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned STACK_PW = STACK_AW + 1;

  localparam int unsigned ENTRY_W  = 21;
  localparam int unsigned LEAF_BIT = 20;

  localparam int unsigned SYM_W   = 16;
  localparam int unsigned COUNT_W = 30;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [4:0] LEAF_BITS = 5'd16;
  localparam logic [2:0] HEADER_LEN = 3'd5;

  localparam logic [2:0] HDR_W_LO = 3'd0;
  localparam logic [2:0] HDR_W_HI = 3'd1;
  localparam logic [2:0] HDR_H_LO = 3'd2;
  localparam logic [2:0] HDR_H_HI = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BIT,
    ST_POP_WRITE,
    ST_WALK_USE,
    ST_EMIT,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

@@ hw/rtl/hsd_ram.sv @@
`default_nettype none
module hsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/huffman_stream_decoder.sv @@
`default_nettype none
// Huffman stream decoder. Accepts one file byte per transfer and returns
// from zero up to eight decoded symbols per byte, each tagged with its
// pixel index and the header mode byte; last marks the final symbol of a
// byte. Payload bytes are handled bit by bit, one pass of the node store
// per bit: a tree-build bit that closes a subtree also pops the pending
// stack and writes the popped node's right-child link, and a decode bit
// reads the node store, then evaluates the child, unless the walk sits on
// a lone leaf or the child index falls outside the store. After a payload
// byte transfer the block stays busy until its bits are handled, plus any
// time spent waiting for the output register to drain. The node store and
// pending stack are single-write, registered-read memories and need no
// clearing.
module huffman_stream_decoder (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [7:0]                  data_byte_i,
  input  wire                         start_of_file_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic signed [15:0]          symbol_o,
  output logic [29:0]                 pixel_index_o,
  output logic [7:0]                  pred_mode_o,
  output logic                        last_o
);
  import hsd_pkg::*;

  state_e state_q, state_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  logic [7:0]  mode_q, mode_d;
  logic [31:0] area_q;
  logic        tree_done_q, tree_done_d;
  logic [NODE_IW-1:0]  nfn_q, nfn_d;
  logic [STACK_PW-1:0] sp_q, sp_d;
  logic [15:0] shift_q, shift_d;
  logic [4:0]  lbl_q, lbl_d;
  logic [NODE_AW-1:0] walk_q, walk_d, child_q, child_d;
  logic [ENTRY_W-1:0] cur_e_q, cur_e_d, root_e_q, root_e_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic        ovf_q, ovf_d;
  logic        hold_v_q, hold_v_d;
  logic [15:0] hold_sym_q, hold_sym_d, cand_sym_q, cand_sym_d;
  logic [COUNT_W-1:0] hold_idx_q, hold_idx_d, cand_idx_q, cand_idx_d;
  logic        out_v_q, out_v_d, out_last_q, out_last_d;
  logic [15:0] out_sym_q, out_sym_d;
  logic [COUNT_W-1:0] out_idx_q, out_idx_d;
  logic [7:0]  out_mode_q, out_mode_d;

  logic                nd_we;
  logic [NODE_AW-1:0]  nd_waddr, nd_raddr;
  logic [ENTRY_W-1:0]  nd_wdata, nd_rdata;
  logic                st_we;
  logic [STACK_AW-1:0] st_waddr, st_raddr;
  logic [NODE_AW-1:0]  st_wdata, st_rdata;

  logic                b;
  logic                bit_done;
  logic [NODE_IW-1:0]  child;
  logic [STACK_PW-1:0] sp_dec;
  logic                emit;

  hsd_ram #(.WIDTH(ENTRY_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (nd_waddr),
    .wdata_i (nd_wdata),
    .raddr_i (nd_raddr),
    .rdata_o (nd_rdata)
  );

  hsd_ram #(.WIDTH(NODE_AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_v_q;
  assign symbol_o      = out_sym_q;
  assign pixel_index_o = out_idx_q;
  assign pred_mode_o   = out_mode_q;
  assign last_o        = out_last_q;

  assign b      = byte_q[bit_q];
  assign sp_dec = sp_q - STACK_PW'(1);
  assign child  = b ? cur_e_q[NODE_IW-1:0] : ({1'b0, walk_q} + NODE_IW'(1));
  assign root_e_d = (nd_we && nd_waddr == '0) ? nd_wdata : root_e_q;

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    bit_d       = bit_q;
    hdr_d       = hdr_q;
    width_d     = width_q;
    height_d    = height_q;
    mode_d      = mode_q;
    tree_done_d = tree_done_q;
    nfn_d       = nfn_q;
    sp_d        = sp_q;
    shift_d     = shift_q;
    lbl_d       = lbl_q;
    walk_d      = walk_q;
    child_d     = child_q;
    cur_e_d     = cur_e_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    hold_v_d    = hold_v_q;
    hold_sym_d  = hold_sym_q;
    hold_idx_d  = hold_idx_q;
    cand_sym_d  = cand_sym_q;
    cand_idx_d  = cand_idx_q;
    out_v_d     = out_v_q && !out_ready_i;
    out_sym_d   = out_sym_q;
    out_idx_d   = out_idx_q;
    out_mode_d  = out_mode_q;
    out_last_d  = out_last_q;
    nd_we       = 1'b0;
    nd_waddr    = nfn_q[NODE_AW-1:0];
    nd_wdata    = '0;
    nd_raddr    = child[NODE_AW-1:0];
    st_we       = 1'b0;
    st_waddr    = sp_q[STACK_AW-1:0];
    st_wdata    = nfn_q[NODE_AW-1:0];
    st_raddr    = sp_dec[STACK_AW-1:0];
    bit_done    = 1'b0;
    emit        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = data_byte_i;
          state_d = ST_CHECK;
          if (start_of_file_i) begin
            hdr_d       = '0;
            width_d     = '0;
            height_d    = '0;
            mode_d      = '0;
            tree_done_d = 1'b0;
            nfn_d       = '0;
            sp_d        = '0;
            lbl_d       = '0;
            walk_d      = '0;
            count_d     = '0;
            ovf_d       = 1'b0;
          end
        end
      end
      ST_CHECK: begin
        bit_d = 3'd7;
        if (ovf_q) begin
          state_d = ST_IDLE;
        end else if (hdr_q < HEADER_LEN) begin
          case (hdr_q)
            HDR_W_LO: width_d[7:0]   = byte_q;
            HDR_W_HI: width_d[15:8]  = byte_q;
            HDR_H_LO: height_d[7:0]  = byte_q;
            HDR_H_HI: height_d[15:8] = byte_q;
            default:  mode_d         = byte_q;
          endcase
          hdr_d   = hdr_q + 3'd1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        if (!tree_done_q) begin
          if (lbl_q != '0) begin
            shift_d = {shift_q[14:0], b};
            lbl_d   = lbl_q - 5'd1;
            if (lbl_q == 5'd1) begin
              if (nfn_q >= NODE_IW'(NODE_COUNT)) begin
                ovf_d   = 1'b1;
                state_d = ST_FLUSH;
              end else begin
                nd_we    = 1'b1;
                nd_wdata = ENTRY_W'({1'b1, 4'b0, shift_q[14:0], b});
                nfn_d    = nfn_q + NODE_IW'(1);
                if (sp_q == '0) begin
                  // tree closed: decoding starts at the root
                  tree_done_d = 1'b1;
                  walk_d      = '0;
                  cur_e_d     = root_e_d;
                  bit_done    = 1'b1;
                end else begin
                  sp_d    = sp_dec;
                  state_d = ST_POP_WRITE;
                end
              end
            end else begin
              bit_done = 1'b1;
            end
          end else if (b) begin
            lbl_d    = LEAF_BITS;
            bit_done = 1'b1;
          end else if (nfn_q >= NODE_IW'(NODE_COUNT) || sp_q >= STACK_PW'(STACK_DEPTH)) begin
            ovf_d   = 1'b1;
            state_d = ST_FLUSH;
          end else begin
            nd_we    = 1'b1;
            nd_wdata = '0;
            st_we    = 1'b1;
            sp_d     = sp_q + STACK_PW'(1);
            nfn_d    = nfn_q + NODE_IW'(1);
            bit_done = 1'b1;
          end
        end else if (cur_e_q[LEAF_BIT]) begin
          bit_done = 1'b1;
        end else if (child >= NODE_IW'(NODE_COUNT)) begin
          walk_d   = '0;
          cur_e_d  = root_e_q;
          bit_done = 1'b1;
        end else begin
          child_d = child[NODE_AW-1:0];
          state_d = ST_WALK_USE;
        end
      end
      ST_POP_WRITE: begin
        // right child of the popped node starts at the next free slot
        nd_we    = 1'b1;
        nd_waddr = st_rdata;
        nd_wdata = ENTRY_W'(nfn_q);
        bit_done = 1'b1;
      end
      ST_WALK_USE: begin
        if (nd_rdata[LEAF_BIT]) begin
          walk_d  = '0;
          cur_e_d = root_e_q;
          if (count_q != COUNT_MAX) begin
            count_d = count_q + COUNT_W'(1);
          end
          emit = (count_q != COUNT_MAX) && ({2'b0, count_q} < area_q);
          cand_sym_d = nd_rdata[15:0];
          cand_idx_d = count_q;
          if (!emit) begin
            bit_done = 1'b1;
          end else if (!hold_v_q) begin
            hold_v_d   = 1'b1;
            hold_sym_d = nd_rdata[15:0];
            hold_idx_d = count_q;
            bit_done   = 1'b1;
          end else if (!out_v_q) begin
            out_v_d    = 1'b1;
            out_sym_d  = hold_sym_q;
            out_idx_d  = hold_idx_q;
            out_mode_d = mode_q;
            out_last_d = 1'b0;
            hold_sym_d = nd_rdata[15:0];
            hold_idx_d = count_q;
            bit_done   = 1'b1;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          walk_d   = child_q;
          cur_e_d  = nd_rdata;
          bit_done = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_v_q) begin
          out_v_d    = 1'b1;
          out_sym_d  = hold_sym_q;
          out_idx_d  = hold_idx_q;
          out_mode_d = mode_q;
          out_last_d = 1'b0;
          hold_sym_d = cand_sym_q;
          hold_idx_d = cand_idx_q;
          bit_done   = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!hold_v_q) begin
          state_d = ST_IDLE;
        end else if (!out_v_q) begin
          out_v_d    = 1'b1;
          out_sym_d  = hold_sym_q;
          out_idx_d  = hold_idx_q;
          out_mode_d = mode_q;
          out_last_d = 1'b1;
          hold_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (bit_done) begin
      if (bit_q == 3'd0) begin
        state_d = ST_FLUSH;
      end else begin
        bit_d   = bit_q - 3'd1;
        state_d = ST_BIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hdr_q       <= '0;
      width_q     <= '0;
      height_q    <= '0;
      mode_q      <= '0;
      tree_done_q <= 1'b0;
      nfn_q       <= '0;
      sp_q        <= '0;
      lbl_q       <= '0;
      walk_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_q       <= hdr_d;
      width_q     <= width_d;
      height_q    <= height_d;
      mode_q      <= mode_d;
      tree_done_q <= tree_done_d;
      nfn_q       <= nfn_d;
      sp_q        <= sp_d;
      lbl_q       <= lbl_d;
      walk_q      <= walk_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      hold_v_q    <= hold_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bit_q      <= bit_d;
    area_q     <= {16'b0, width_q} * {16'b0, height_q};
    shift_q    <= shift_d;
    child_q    <= child_d;
    cur_e_q    <= cur_e_d;
    root_e_q   <= root_e_d;
    hold_sym_q <= hold_sym_d;
    hold_idx_q <= hold_idx_d;
    cand_sym_q <= cand_sym_d;
    cand_idx_q <= cand_idx_d;
    out_sym_q  <= out_sym_d;
    out_idx_q  <= out_idx_d;
    out_mode_q <= out_mode_d;
    out_last_q <= out_last_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/hsd_checker.sv @@
`default_nettype none
module hsd_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire signed [15:0] symbol_o,
  input wire [29:0]        pixel_index_o,
  input wire [7:0]         pred_mode_o,
  input wire               last_o
);

  logic        more_q;
  logic [29:0] prev_idx_q;
  logic [7:0]  prev_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      more_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      more_q <= !last_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      prev_idx_q  <= pixel_index_o;
      prev_mode_q <= pred_mode_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o)
      && $stable(pixel_index_o) && $stable(last_o))
    else $error("output changed while stalled");

  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("byte transfer did not start a decode pass");

  a_idx_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && more_q |-> pixel_index_o > prev_idx_q)
    else $error("pixel index not rising within a byte");

  a_mode_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && more_q |-> pred_mode_o == prev_mode_q)
    else $error("mode changed within a byte");

endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .symbol_o      (symbol_o),
  .pixel_index_o (pixel_index_o),
  .pred_mode_o   (pred_mode_o),
  .last_o        (last_o)
);
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import hsd_pkg::*;

  typedef struct packed {
    logic [15:0] symbol;
    logic [29:0] pixel_index;
    logic [7:0]  pred_mode;
    logic        last;
  } symbol_rec_t;

  localparam logic [31:0] LEAF_MARK = 32'h8000_0000;
  localparam logic [31:0] CHILD_MASK = 32'h0001_FFFF;
  localparam logic [29:0] SYM_COUNT_MAX = 30'h3FFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        start_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] symbol_o;
  logic [29:0] pixel_index_o;
  logic [7:0]  pred_mode_o;
  logic        last_o;

  huffman_stream_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_o        (symbol_o),
    .pixel_index_o   (pixel_index_o),
    .pred_mode_o     (pred_mode_o),
    .last_o          (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Decoder state mirror
  logic [31:0] tree_nodes [0:NODE_COUNT-1];
  int unsigned open_nodes [0:STACK_DEPTH-1];
  int unsigned hdr_cnt, img_w, img_h, mode_val, tree_built, free_node, open_cnt;
  int unsigned leaf_acc, leaf_left, walk_at, sym_cnt, halted;

  symbol_rec_t pending_symbols[$];
  bit          file_bits[$];
  int          error_count = 0;
  int          bytes_sent = 0;
  int          symbols_seen = 0;
  int          files_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_symbols(input logic [7:0] b, input logic sof);
    symbol_rec_t found[$];
    symbol_rec_t r;
    logic        bt;
    logic [31:0] e, ce;
    int unsigned cur, child, idx;
    if (sof) begin
      hdr_cnt = 0; img_w = 0; img_h = 0; mode_val = 0; tree_built = 0;
      free_node = 0; open_cnt = 0; leaf_acc = 0; leaf_left = 0; walk_at = 0;
      sym_cnt = 0; halted = 0;
    end
    if (halted != 0) return;
    if (hdr_cnt < 5) begin
      case (hdr_cnt)
        HDR_W_LO: img_w = (img_w & 32'hFF00) | 32'(b);
        HDR_W_HI: img_w = (img_w & 32'h00FF) | (32'(b) << 8);
        HDR_H_LO: img_h = (img_h & 32'hFF00) | 32'(b);
        HDR_H_HI: img_h = (img_h & 32'h00FF) | (32'(b) << 8);
        default:  mode_val = 32'(b);
      endcase
      hdr_cnt++;
      return;
    end
    for (int i = 7; i >= 0; i--) begin
      bt = b[i];
      if (tree_built == 0) begin
        if (leaf_left > 0) begin
          leaf_acc = ((leaf_acc << 1) | 32'(bt)) & 32'hFFFF;
          leaf_left--;
          if (leaf_left == 0) begin
            if (free_node >= NODE_COUNT) begin
              halted = 1;
              break;
            end
            tree_nodes[free_node] = LEAF_MARK | leaf_acc;
            free_node++;
            if (open_cnt == 0) begin
              tree_built = 1;
              walk_at = 0;
            end else begin
              open_cnt--;
              tree_nodes[open_nodes[open_cnt]] = free_node & CHILD_MASK;
            end
          end
        end else if (bt) begin
          leaf_left = 16;
        end else begin
          if (free_node >= NODE_COUNT || open_cnt >= STACK_DEPTH) begin
            halted = 1;
            break;
          end
          tree_nodes[free_node] = '0;
          open_nodes[open_cnt] = free_node;
          open_cnt++;
          free_node++;
        end
      end else begin
        cur = walk_at;
        if (cur >= NODE_COUNT) begin
          walk_at = 0;
          continue;
        end
        e = tree_nodes[cur];
        if (e[31]) continue;
        child = bt ? (e & CHILD_MASK) : cur + 1;
        if (child >= NODE_COUNT) begin
          walk_at = 0;
          continue;
        end
        ce = tree_nodes[child];
        if (ce[31]) begin
          walk_at = 0;
          idx = sym_cnt;
          if (sym_cnt < SYM_COUNT_MAX) sym_cnt++;
          if (idx < SYM_COUNT_MAX && longint'(idx) < longint'(img_w) * longint'(img_h)) begin
            r.symbol = ce[15:0];
            r.pixel_index = idx[29:0];
            r.pred_mode = mode_val[7:0];
            r.last = 1'b0;
            found.push_back(r);
          end
        end else begin
          walk_at = child;
        end
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[k]) pending_symbols.push_back(found[k]);
  endfunction

  // Offer one byte; expectations are formed at the transfer.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    data_byte_i = b;
    start_of_file_i = sof;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_symbols(b, sof);
    bytes_sent++;
  endtask

  task automatic add_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) file_bits.push_back(v[i]);
  endtask

  task automatic add_header(input logic [15:0] w, input logic [15:0] h, input logic [7:0] m);
    add_bits(32'(w[7:0]), 8); add_bits(32'(w[15:8]), 8);
    add_bits(32'(h[7:0]), 8); add_bits(32'(h[15:8]), 8);
    add_bits(32'(m), 8);
  endtask

  task automatic add_tree(input int depth, input bit force_node);
    if (!force_node && (depth == 0 || $urandom_range(2) == 0)) begin
      add_bits(1, 1);
      add_bits($urandom_range(16'hFFFF), 16);
    end else begin
      add_bits(0, 1);
      add_tree(depth - 1, 1'b0);
      add_tree(depth - 1, 1'b0);
    end
  endtask

  task automatic add_payload(input int nbytes);
    repeat (nbytes * 8) add_bits($urandom_range(1), 1);
  endtask

  // Pack the bit stream MSB first; the first byte opens the file.
  task automatic send_file();
    logic [7:0] b;
    bit first;
    first = 1'b1;
    while (file_bits.size() % 8 != 0) file_bits.push_back($urandom_range(1));
    while (file_bits.size() > 0) begin
      for (int i = 7; i >= 0; i--) b[i] = file_bits.pop_front();
      send_byte(b, first);
      first = 1'b0;
    end
    files_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    symbol_rec_t exp_sym;
    if (rst_ni && out_valid_o && out_ready_i) begin
      symbols_seen++;
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %h", symbol_o));
      end else begin
        exp_sym = pending_symbols.pop_front();
        if (symbol_o !== exp_sym.symbol)
          report_mismatch($sformatf("symbol %h exp %h", symbol_o, exp_sym.symbol));
        if (pixel_index_o !== exp_sym.pixel_index)
          report_mismatch($sformatf("pixel_index %0d exp %0d", pixel_index_o,
                                    exp_sym.pixel_index));
        if (pred_mode_o !== exp_sym.pred_mode)
          report_mismatch($sformatf("pred_mode %h exp %h", pred_mode_o, exp_sym.pred_mode));
        if (last_o !== exp_sym.last)
          report_mismatch($sformatf("last %b exp %b", last_o, exp_sym.last));
      end
    end
  end

  // Four leaves at the value extremes, large image, all-ones mode.
  task automatic test_field_extremes();
    add_header(16'hFFFF, 16'hFFFF, 8'hFF);
    add_bits(0, 1); add_bits(0, 1);
    add_bits(1, 1); add_bits(32'h0000_0000, 16);
    add_bits(1, 1); add_bits(32'h0000_FFFF, 16);
    add_bits(0, 1);
    add_bits(1, 1); add_bits(32'h0000_8000, 16);
    add_bits(1, 1); add_bits(32'h0000_7FFF, 16);
    add_bits(32'h00FF_00AA, 32);
    send_file();
  endtask

  // Symbols past width*height are dropped; zero area drops all.
  task automatic test_image_bounds();
    add_header(16'd3, 16'd1, 8'h00);
    add_tree(2, 1'b1);
    add_payload(4);
    send_file();
    add_header(16'd0, 16'd77, 8'h5A);
    add_tree(1, 1'b1);
    add_payload(2);
    send_file();
  endtask

  task automatic test_lone_leaf();
    add_header(16'd10, 16'd10, 8'h11);
    add_bits(1, 1); add_bits(32'h0000_1234, 16);
    add_payload(3);
    send_file();
  endtask

  // Too deep for the pending stack; the rest of the file is ignored.
  task automatic test_overflow();
    add_header(16'd8, 16'd8, 8'h22);
    repeat (STACK_DEPTH + 8) add_bits(0, 1);
    add_payload(3);
    send_file();
    drain();
  endtask

  // Receiver stalls long enough to back the block up into its input.
  task automatic test_output_stall();
    @(negedge clk_i);
    recv_hold = 400;
    add_header(16'd200, 16'd200, 8'h44);
    add_tree(1, 1'b1);
    add_payload(30);
    send_file();
    drain();
  endtask

  task automatic test_random_files(input int budget);
    int start_bytes, dice;
    logic [15:0] w, h;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < budget) begin
      dice = $urandom_range(9);
      if (dice == 0) begin
        // stray bytes continue the current file
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end else if (dice == 1) begin
        // broken file: random tree bits
        send_byte(8'($urandom_range(255)), 1'b1);
        repeat ($urandom_range(4, 10)) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        w = ($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF))
                                     : 16'($urandom_range(1, 12));
        h = ($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF))
                                     : 16'($urandom_range(0, 6));
        add_header(w, h, 8'($urandom_range(255)));
        add_tree($urandom_range(1, 5), 1'b1);
        add_payload($urandom_range(4, 16));
        send_file();
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 15; recv_idle_pct = 53;
    test_field_extremes();
    test_image_bounds();
    test_lone_leaf();
    drain();
    test_overflow();
    test_output_stall();
    test_random_files(70);
    send_idle_pct = 53; recv_idle_pct = 15;
    test_random_files(70);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_files(70);

    $display("covered %0d files, %0d bytes, %0d symbols checked", files_sent, bytes_sent,
             symbols_seen);
    $display("header extremes, dropped pixels, lone leaf, stack overflow, stalls");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ huffman_stream_decoder.f @@
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_ram.sv
hw/rtl/huffman_stream_decoder.sv
hw/rtl/hsd_checker.sv
verif/testbench.sv
